// ===== hdl/tsti_pkg.sv =====
// Shared types and constants for the triode stage table interpolation solver.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package tsti_pkg;

  localparam int GRID_BINS    = 257;
  localparam int PLATE_BINS   = 385;
  localparam int SOLVE_ROUNDS = 4;

  localparam int TBL_DEPTH = GRID_BINS * PLATE_BINS;
  localparam int ADDR_W    = 17;
  localparam int CELL_W    = 10;
  localparam int RND_W     = (SOLVE_ROUNDS > 1) ? $clog2(SOLVE_ROUNDS) : 1;

  localparam int GRID_W  = 27;
  localparam int VOLT_W  = 26;
  localparam int STEP_W  = 32;
  localparam int LOAD_W  = 24;
  localparam int SCALE_W = 16;
  localparam int CUR_W   = 32;
  localparam int WGT_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLATE_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_INV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLATE_INV  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REST       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD       = 3'd7;

  localparam logic OP_TABLE_WRITE = 1'b0;
  localparam logic OP_SAMPLE      = 1'b1;

  typedef enum logic [3:0] {
    MUL_SUPPLY, MUL_REST, MUL_GRID, MUL_PLATE,
    MUL_LO_A, MUL_LO_B, MUL_V_A, MUL_V_B, MUL_DROP
  } mul_sel_t;

  typedef enum logic [1:0] {
    RD_BASE, RD_BASE1, RD_NEXT, RD_NEXT1
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUP, ST_REST, ST_GRID, ST_GLOC, ST_PMUL, ST_PLOC,
    ST_RD1, ST_RD2, ST_RD3, ST_B1, ST_B2, ST_B3, ST_B4, ST_DROP, ST_UPD
  } state_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    rd_sel_t  rd_sel;
    logic     tbl_wr;
    logic     start;
    logic     ld_sup;
    logic     ld_rest;
    logic     ld_gloc;
    logic     ld_ploc;
    logic     rd_en;
    logic     ld_acc;
    logic     ld_lo;
    logic     ld_hi;
    logic     ld_cur;
    logic     upd;
    logic     done;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/tsti_ctrl.sv =====
// Sequencing state machine: issues datapath commands for each solver round.
// Depends on tsti_pkg.
`default_nettype none

module tsti_ctrl
  import tsti_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  wire  in_operation,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic out_valid_r, out_valid_nxt;
  logic last_rnd;
  logic out_free;

  assign last_rnd = (rnd_r == RND_W'(SOLVE_ROUNDS - 1));
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && in_operation == OP_SAMPLE) state_nxt = ST_SUP;
      ST_SUP:  state_nxt = ST_REST;
      ST_REST: state_nxt = ST_GRID;
      ST_GRID: state_nxt = ST_GLOC;
      ST_GLOC: state_nxt = ST_PLOC;
      ST_PMUL: state_nxt = ST_PLOC;
      ST_PLOC: state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_RD3;
      ST_RD3:  state_nxt = ST_B1;
      ST_B1:   state_nxt = ST_B2;
      ST_B2:   state_nxt = ST_B3;
      ST_B3:   state_nxt = ST_B4;
      ST_B4:   state_nxt = ST_DROP;
      ST_DROP: state_nxt = ST_UPD;
      // hold the last round until the output register is free
      ST_UPD: begin
        if (!last_rnd) state_nxt = ST_PMUL;
        else if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_SUPPLY;
    cmd.rd_sel = RD_BASE;
    rnd_nxt = rnd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        cmd.tbl_wr = in_valid && (in_operation == OP_TABLE_WRITE);
        cmd.start = in_valid && (in_operation == OP_SAMPLE);
        rnd_nxt = '0;
      end
      ST_SUP: cmd.mul_sel = MUL_SUPPLY;
      ST_REST: begin
        cmd.ld_sup = 1'b1;
        cmd.mul_sel = MUL_REST;
      end
      ST_GRID: begin
        cmd.ld_rest = 1'b1;
        cmd.mul_sel = MUL_GRID;
      end
      ST_GLOC: begin
        cmd.ld_gloc = 1'b1;
        cmd.mul_sel = MUL_PLATE;
      end
      ST_PMUL: cmd.mul_sel = MUL_PLATE;
      ST_PLOC: begin
        cmd.ld_ploc = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_BASE;
      end
      ST_RD1: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_BASE1;
        cmd.mul_sel = MUL_LO_A;
      end
      ST_RD2: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_NEXT;
        cmd.ld_acc = 1'b1;
        cmd.mul_sel = MUL_LO_B;
      end
      ST_RD3: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_NEXT1;
        cmd.ld_lo = 1'b1;
        cmd.mul_sel = MUL_LO_A;
      end
      ST_B1: begin
        cmd.ld_acc = 1'b1;
        cmd.mul_sel = MUL_LO_B;
      end
      ST_B2: begin
        cmd.ld_hi = 1'b1;
        cmd.mul_sel = MUL_V_A;
      end
      ST_B3: begin
        cmd.ld_acc = 1'b1;
        cmd.mul_sel = MUL_V_B;
      end
      ST_B4: cmd.ld_cur = 1'b1;
      ST_DROP: cmd.mul_sel = MUL_DROP;
      ST_UPD: begin
        // keep the drop product steady while the result waits
        cmd.mul_sel = MUL_DROP;
        if (!last_rnd) begin
          cmd.upd = 1'b1;
          rnd_nxt = rnd_r + RND_W'(1);
        end else if (out_free) begin
          cmd.upd = 1'b1;
          cmd.done = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tsti_dp.sv =====
// Datapath: configuration registers, current table memory, shared multiplier,
// bilinear blend and plate update. Depends on tsti_pkg; driven by tsti_ctrl.
`default_nettype none

module tsti_dp
  import tsti_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  cmd_t                       cmd,
  input  wire                        cfg_wr,
  input  wire        [CFG_IDX_W-1:0] cfg_index,
  input  wire        [CFG_DAT_W-1:0] cfg_data,
  input  wire        [ADDR_W-1:0]    in_table_address,
  input  wire        [CUR_W-1:0]     in_table_value,
  input  wire signed [GRID_W-1:0]    in_grid_voltage,
  input  wire        [SCALE_W-1:0]   in_supply_scale,
  output logic signed [GRID_W-1:0]   out_plate_swing
);

  localparam logic [VOLT_W-1:0] VOLT_SAT = {VOLT_W{1'b1}};

  logic signed [GRID_W-1:0] grid_min_r, grid_max_r;
  logic [VOLT_W-1:0] plate_max_r, supply_v_r, rest_v_r;
  logic [STEP_W-1:0] grid_inv_r, plate_inv_r;
  logic [LOAD_W-1:0] load_r;

  logic signed [GRID_W-1:0] grid_r;
  logic [SCALE_W-1:0] scale_r;
  logic [VOLT_W-1:0] supply_r, rest_r, pw_r, pv_r;
  logic [CELL_W-1:0] x0_r;
  logic [WGT_W-1:0] tx_r, ty_r;
  logic [ADDR_W-1:0] base_r;
  logic [63:0] mul_r;
  logic [48:0] acc_r;
  logic [CUR_W-1:0] rd_r, lo_r, hi_r, cur_r;
  logic signed [GRID_W-1:0] swing_r;

  logic [CUR_W-1:0] mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_min_r <= -27'sd9175040;
      grid_max_r <= 27'sd655360;
      plate_max_r <= 26'd21626880;
      grid_inv_r <= 32'd28633115;
      plate_inv_r <= 32'd19522422;
      supply_v_r <= 26'd16384000;
      rest_v_r <= 26'd9830400;
      load_r <= 24'd100000;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_GRID_MIN:  grid_min_r <= GRID_W'(cfg_data);
        REG_GRID_MAX:  grid_max_r <= GRID_W'(cfg_data);
        REG_PLATE_MAX: plate_max_r <= cfg_data[VOLT_W-1:0];
        REG_GRID_INV:  grid_inv_r <= cfg_data;
        REG_PLATE_INV: plate_inv_r <= cfg_data;
        REG_SUPPLY:    supply_v_r <= cfg_data[VOLT_W-1:0];
        REG_REST:      rest_v_r <= cfg_data[VOLT_W-1:0];
        REG_LOAD:      load_r <= cfg_data[LOAD_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp grid, then form its offset from the lower bound
  logic signed [GRID_W-1:0] g_lo, g_cl;
  logic signed [GRID_W:0] g_diff;
  logic [GRID_W:0] goff;
  logic [VOLT_W-1:0] poff;
  always_comb begin
    g_lo = (grid_r < grid_min_r) ? grid_min_r : grid_r;
    g_cl = (g_lo > grid_max_r) ? grid_max_r : g_lo;
    g_diff = {g_cl[GRID_W-1], g_cl} - {grid_min_r[GRID_W-1], grid_min_r};
    goff = (g_cl > grid_min_r) ? g_diff : '0;
    poff = (pw_r > plate_max_r) ? plate_max_r : pw_r;
  end

  logic [27:0] sat_src;
  logic [VOLT_W-1:0] sat_val, rest_cl;
  assign sat_src = mul_r[41:14];
  assign sat_val = (sat_src > 28'(VOLT_SAT)) ? VOLT_SAT : sat_src[VOLT_W-1:0];
  assign rest_cl = (sat_val > supply_r) ? supply_r : sat_val;

  // cell index and weight from a Q.40 position
  logic [23:0] whole;
  logic gsat, psat;
  logic [CELL_W-1:0] cell_g, cell_p;
  logic [WGT_W-1:0] wgt_g, wgt_p;
  always_comb begin
    whole = mul_r[63:40];
    gsat = whole > 24'(GRID_BINS - 2);
    psat = whole > 24'(PLATE_BINS - 2);
    cell_g = gsat ? CELL_W'(GRID_BINS - 2) : whole[CELL_W-1:0];
    wgt_g = gsat ? ONE_Q16 : {1'b0, mul_r[39:24]};
    cell_p = psat ? CELL_W'(PLATE_BINS - 2) : whole[CELL_W-1:0];
    wgt_p = psat ? ONE_Q16 : {1'b0, mul_r[39:24]};
  end

  logic [ADDR_W+CELL_W-1:0] base_wide;
  logic [ADDR_W-1:0] base_c, base_cur, rd_addr;
  assign base_wide = cell_p * (ADDR_W+CELL_W)'(GRID_BINS) + (ADDR_W+CELL_W)'(x0_r);
  assign base_c = base_wide[ADDR_W-1:0];
  assign base_cur = cmd.ld_ploc ? base_c : base_r;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_BASE:  rd_addr = base_cur;
      RD_BASE1: rd_addr = base_cur + ADDR_W'(1);
      RD_NEXT:  rd_addr = base_cur + ADDR_W'(GRID_BINS);
      RD_NEXT1: rd_addr = base_cur + ADDR_W'(GRID_BINS + 1);
      default:  rd_addr = base_cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && in_table_address < ADDR_W'(TBL_DEPTH)) begin
      mem[in_table_address] <= in_table_value;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  logic [31:0] op_a, op_b;
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SUPPLY: begin op_a = 32'(supply_v_r); op_b = 32'(scale_r); end
      MUL_REST:   begin op_a = 32'(rest_v_r); op_b = 32'(scale_r); end
      MUL_GRID:   begin op_a = 32'(goff); op_b = grid_inv_r; end
      MUL_PLATE:  begin op_a = 32'(poff); op_b = plate_inv_r; end
      MUL_LO_A:   begin op_a = rd_r; op_b = 32'(ONE_Q16 - tx_r); end
      MUL_LO_B:   begin op_a = rd_r; op_b = 32'(tx_r); end
      MUL_V_A:    begin op_a = lo_r; op_b = 32'(ONE_Q16 - ty_r); end
      MUL_V_B:    begin op_a = hi_r; op_b = 32'(ty_r); end
      MUL_DROP:   begin op_a = cur_r; op_b = 32'(load_r); end
      default:    begin op_a = '0; op_b = '0; end
    endcase
  end

  logic [49:0] blend_sum;
  logic [CUR_W-1:0] blend_val;
  assign blend_sum = 50'(acc_r) + 50'(mul_r[48:0]);
  assign blend_val = blend_sum[47:16];

  logic [39:0] drop;
  logic [VOLT_W-1:0] target;
  logic [VOLT_W:0] pw_sum;
  always_comb begin
    drop = mul_r[55:16];
    target = (drop >= 40'(supply_r)) ? '0 : supply_r - drop[VOLT_W-1:0];
    pw_sum = {1'b0, pw_r} + {1'b0, target};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (cmd.done) begin
      pv_r <= pw_sum[VOLT_W:1];
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= op_a * op_b;
    if (cmd.start) begin
      grid_r <= in_grid_voltage;
      scale_r <= in_supply_scale;
    end
    if (cmd.ld_sup) supply_r <= sat_val;
    if (cmd.ld_rest) begin
      rest_r <= rest_cl;
      // start from the quiescent point when nothing is stored yet
      pw_r <= (pv_r != '0) ? pv_r : rest_cl;
    end
    if (cmd.ld_gloc) begin
      x0_r <= cell_g;
      tx_r <= wgt_g;
    end
    if (cmd.ld_ploc) begin
      ty_r <= wgt_p;
      base_r <= base_c;
    end
    if (cmd.ld_acc) acc_r <= mul_r[48:0];
    if (cmd.ld_lo) lo_r <= blend_val;
    if (cmd.ld_hi) hi_r <= blend_val;
    if (cmd.ld_cur) cur_r <= blend_val;
    if (cmd.upd) pw_r <= pw_sum[VOLT_W:1];
    if (cmd.done) swing_r <= GRID_W'({1'b0, rest_r}) - GRID_W'(pw_sum[VOLT_W:1]);
  end

  assign out_plate_swing = swing_r;

endmodule

`default_nettype wire

// ===== hdl/triode_stage_table_interp_solver_core.sv =====
// Top level of the triode stage table interpolation solver.
// Depends on tsti_pkg, tsti_ctrl and tsti_dp.
//
// Use: load the plate current table first with operation 0 words (address,
// value); each is taken while the block is idle and gives no result. Out-of-range
// addresses are dropped. An operation 1 word carries a grid voltage and a
// supply scale and gives one plate_swing word on the result channel.
// Configuration writes (cfg_index, cfg_data) are always taken and belong
// between samples, while the block is idle.
// The input is ready again in the same cycle as the result of a sample appears
// in the output register.
// Each round is set by the single shared multiplier and the single read port
// of the table memory: four reads and eight products in sequence.
// The result sits in an output register; table writes are still taken while
// it waits. A following sample finishes its rounds and then holds until the
// receiver takes the earlier word.
// Reset restores the default registers and clears the stored plate voltage,
// so the next sample starts from the scaled quiescent point. The table
// memory is not cleared.
`default_nettype none

module triode_stage_table_interp_solver_core
  import tsti_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_operation,
  input  wire        [ADDR_W-1:0]     in_table_address,
  input  wire        [CUR_W-1:0]      in_table_value,
  input  wire signed [GRID_W-1:0]     in_grid_voltage,
  input  wire        [SCALE_W-1:0]    in_supply_scale,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [GRID_W-1:0]    out_plate_swing,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire        [CFG_IDX_W-1:0]  cfg_index,
  input  wire        [CFG_DAT_W-1:0]  cfg_data
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  tsti_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  tsti_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_table_address (in_table_address),
    .in_table_value   (in_table_value),
    .in_grid_voltage  (in_grid_voltage),
    .in_supply_scale  (in_supply_scale),
    .out_plate_swing  (out_plate_swing)
  );

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation |=> !in_ready)
    else $error("sample accept did not start a solve");

  a_write_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_operation |=> in_ready)
    else $error("table write blocked the input");

  a_result_after_solve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a solve");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.tbl_wr && cmd.start))
    else $error("table write and sample start together");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for triode_stage_table_interp_solver_core.
// Depends on tsti_pkg and the core RTL; fills the current table, then runs directed and
// random samples under several register settings against a built-in solver predictor.
`default_nettype none

module tb
  import tsti_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF = 60;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_operation;
  logic        [ADDR_W-1:0]  in_table_address;
  logic        [CUR_W-1:0]   in_table_value;
  logic signed [GRID_W-1:0]  in_grid_voltage;
  logic        [SCALE_W-1:0] in_supply_scale;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [GRID_W-1:0]  out_plate_swing;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic        [CFG_IDX_W-1:0] cfg_index;
  logic        [CFG_DAT_W-1:0] cfg_data;

  triode_stage_table_interp_solver_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_table_address(in_table_address), .in_table_value(in_table_value),
    .in_grid_voltage(in_grid_voltage), .in_supply_scale(in_supply_scale),
    .out_valid(out_valid), .out_ready(out_ready), .out_plate_swing(out_plate_swing),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block's registers and state
  logic [CUR_W-1:0] cur_tbl [0:TBL_DEPTH-1];
  logic [31:0]      plate_state;
  longint           grid_lo, grid_hi;
  logic [31:0]      plate_top, grid_inv, plate_inv, supply_v, rest_v, load_r;

  logic signed [GRID_W-1:0] swing_q [$];
  int  errors;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  typed_pending;
  logic signed [GRID_W-1:0] typed_swing;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [31:0] scale_clip(logic [31:0] v, logic [15:0] s);
    logic [63:0] p;
    p = (64'(v) * 64'(s)) >> 14;
    return (p > 64'd67108863) ? 32'd67108863 : p[31:0];
  endfunction

  function automatic void find_cell(logic [63:0] offs, logic [31:0] inv, int nbins,
                                    output int idx, output logic [16:0] wt);
    logic [63:0] pos;
    pos = offs * 64'(inv);
    if ((pos >> 40) > 64'(nbins - 2)) begin
      idx = nbins - 2;
      wt  = ONE_Q16;
    end else begin
      idx = int'(pos >> 40);
      wt  = {1'b0, pos[39:24]};
    end
  endfunction

  function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [16:0] t);
    return (a * (64'd65536 - 64'(t)) + b * 64'(t)) >> 16;
  endfunction

  function automatic logic [63:0] lookup_current(longint g_in, logic [31:0] plate);
    longint      g;
    logic [63:0] goff, poff, lo, hi;
    int          x0, y0, base;
    logic [16:0] tx, ty;
    g = g_in;
    if (g < grid_lo) g = grid_lo;
    if (g > grid_hi) g = grid_hi;
    goff = (g > grid_lo) ? 64'(g - grid_lo) : 64'd0;
    poff = (plate > plate_top) ? 64'(plate_top) : 64'(plate);
    find_cell(goff, grid_inv, GRID_BINS, x0, tx);
    find_cell(poff, plate_inv, PLATE_BINS, y0, ty);
    base = y0 * GRID_BINS + x0;
    lo = mix(64'(cur_tbl[base]), 64'(cur_tbl[base + 1]), tx);
    hi = mix(64'(cur_tbl[base + GRID_BINS]), 64'(cur_tbl[base + GRID_BINS + 1]), tx);
    return mix(lo, hi, ty);
  endfunction

  // run the damped load-line rounds and return the plate swing
  function automatic logic signed [GRID_W-1:0] solve_plate(logic signed [GRID_W-1:0] grid,
                                                           logic [15:0] scale);
    logic [31:0] sup, rest, plate, target;
    logic [63:0] drop;
    longint      sw;
    sup  = scale_clip(supply_v, scale);
    rest = scale_clip(rest_v, scale);
    if (rest > sup) rest = sup;
    plate = (plate_state > 0) ? plate_state : rest;
    for (int r = 0; r < SOLVE_ROUNDS; r++) begin
      drop   = (lookup_current(longint'(grid), plate) * 64'(load_r)) >> 16;
      target = (drop >= 64'(sup)) ? 32'd0 : sup - drop[31:0];
      plate  = 32'((64'(plate) + 64'(target)) >> 1);
    end
    plate_state = plate;
    sw = longint'(rest) - longint'(plate);
    return sw[GRID_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (swing_q.size() == 0) begin
        $error("plate_swing: unexpected word %0d", out_plate_swing);
        errors++;
      end else begin
        if (out_plate_swing !== swing_q[0]) begin
          $error("plate_swing: expected %0d, got %0d", swing_q[0], out_plate_swing);
          errors++;
        end
        void'(swing_q.pop_front());
      end
    end
    if (rst_n && in_valid && in_ready) begin
      if (in_operation == OP_TABLE_WRITE) begin
        if (in_table_address < TBL_DEPTH) cur_tbl[in_table_address] = in_table_value;
      end else if (typed_pending) begin
        void'(solve_plate(in_grid_voltage, in_supply_scale));
        swing_q.push_back(typed_swing);
        typed_pending = 1'b0;
      end else begin
        swing_q.push_back(solve_plate(in_grid_voltage, in_supply_scale));
      end
    end
  end

  always @(negedge clk) begin
    if (rx_idle_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_word(logic op, logic [ADDR_W-1:0] addr, logic [CUR_W-1:0] val,
                           logic signed [GRID_W-1:0] grid, logic [SCALE_W-1:0] scale);
    int gap;
    gap = (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid         = 1'b1;
    in_operation     = op;
    in_table_address = addr;
    in_table_value   = val;
    in_grid_voltage  = grid;
    in_supply_scale  = scale;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every result is in, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (swing_q.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GRID_MIN:  grid_lo   = longint'($signed(val[GRID_W-1:0]));
      REG_GRID_MAX:  grid_hi   = longint'($signed(val[GRID_W-1:0]));
      REG_PLATE_MAX: plate_top = {6'd0, val[VOLT_W-1:0]};
      REG_GRID_INV:  grid_inv  = val;
      REG_PLATE_INV: plate_inv = val;
      REG_SUPPLY:    supply_v  = {6'd0, val[VOLT_W-1:0]};
      REG_REST:      rest_v    = {6'd0, val[VOLT_W-1:0]};
      default:       load_r    = {8'd0, val[LOAD_W-1:0]};
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(int n);
    logic [31:0] v [8];
    case (n)
      0: v = '{-32'sd9175040, 32'd655360, 32'd21626880, 32'd28633115, 32'd19522422,
               32'd16384000, 32'd9830400, 32'd100000};
      1: v = '{-32'sd65536000, 32'd65536000, 32'd65536000, 32'hFFFFFFFF, 32'hFFFFFFFF,
               32'd65536000, 32'd65536000, 32'd16777215};
      2: v = '{32'd655360, -32'sd655360, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1};
      3: v = '{-32'sd9175040, 32'd655360, 32'd21626880, 32'd28633115, 32'd19522422,
               32'd16384000, 32'd9830400, 32'd0};
      4: v = '{-32'sd655360, 32'd0, 32'd65536000, 32'd0, 32'd0,
               32'd67108863, 32'd67108863, 32'd1};
      default: begin
        v[0] = -32'($urandom_range(20000000));
        v[1] = $urandom_range(20000000);
        v[2] = $urandom_range(65536000);
        v[3] = $urandom_range(60000000);
        v[4] = $urandom_range(40000000);
        v[5] = $urandom_range(65536000);
        v[6] = $urandom_range(65536000);
        v[7] = $urandom_range(1, 400000);
        if ($urandom_range(3) == 0) begin
          v[0] = $urandom;
          v[1] = $urandom;
        end
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), v[i]);
  endtask

  typedef struct {
    logic                     op;
    logic [ADDR_W-1:0]        addr;
    logic [CUR_W-1:0]         val;
    logic signed [GRID_W-1:0] grid;
    logic [SCALE_W-1:0]       scale;
    bit                       typed;
    logic signed [GRID_W-1:0] swing;
  } vec_t;

  vec_t vecs [] = '{
    '{OP_SAMPLE, 0, 0, 0, 16'd0, 1, 0},   // first sample, no supply: stays at zero
    '{OP_SAMPLE, 0, 0, 0, 16'd16384, 0, 0},
    '{OP_SAMPLE, 0, 0, 27'sh4000000, 16'd65535, 0, 0},
    '{OP_SAMPLE, 0, 0, 27'sh3FFFFFF, 16'd1, 0, 0},
    '{OP_SAMPLE, 0, 0, -27'sd65536000, 16'd16384, 0, 0},
    '{OP_SAMPLE, 0, 0, 27'sd65536000, 16'd32768, 0, 0},
    '{OP_TABLE_WRITE, 17'h1FFFF, 32'hFFFFFFFF, 0, 0, 0, 0},
    '{OP_TABLE_WRITE, 17'd98945, 32'd0, 0, 0, 0, 0},
    '{OP_TABLE_WRITE, 17'd0, 32'd0, 0, 0, 0, 0},
    '{OP_TABLE_WRITE, 17'd98944, 32'hFFFFFFFF, 0, 0, 0, 0},
    '{OP_SAMPLE, 0, 0, -27'sd9175040, 16'd16384, 0, 0},
    '{OP_SAMPLE, 0, 0, 27'sd655360, 16'd16384, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 16'd0, 0, 0},
    '{OP_SAMPLE, 0, 0, -27'sd4000000, 16'hFFFF, 0, 0}
  };

  task automatic random_word();
    logic [ADDR_W-1:0] a;
    if ($urandom_range(99) < 30) begin
      a = ($urandom_range(9) == 0) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(TBL_DEPTH - 1));
      send_word(OP_TABLE_WRITE, a,
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 22),
                GRID_W'($urandom), SCALE_W'($urandom));
    end else begin
      send_word(OP_SAMPLE, ADDR_W'($urandom), $urandom,
                ($urandom_range(7) == 0) ? GRID_W'($urandom)
                                         : GRID_W'($urandom_range(131072000) - 65536000),
                ($urandom_range(3) == 0) ? SCALE_W'($urandom)
                                         : SCALE_W'($urandom_range(12000, 20000)));
    end
  endtask

  initial begin
    errors = 0;
    typed_pending = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_TABLE_WRITE;
    in_table_address = '0;
    in_table_value = '0;
    in_grid_voltage = '0;
    in_supply_scale = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    plate_state = '0;
    grid_lo = -9175040;
    grid_hi = 655360;
    plate_top = 32'd21626880;
    grid_inv = 32'd28633115;
    plate_inv = 32'd19522422;
    supply_v = 32'd16384000;
    rest_v = 32'd9830400;
    load_r = 32'd100000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // load every entry so no lookup ever meets an unwritten one
    for (int i = 0; i < TBL_DEPTH; i++)
      send_word(OP_TABLE_WRITE, ADDR_W'(i), $urandom_range(1 << 22), 0, 0);

    foreach (vecs[i]) begin
      if (vecs[i].op == OP_SAMPLE && vecs[i].typed) begin
        wait (!typed_pending);
        typed_pending = 1'b1;
        typed_swing = vecs[i].swing;
      end
      send_word(vecs[i].op, vecs[i].addr, vecs[i].val, vecs[i].grid, vecs[i].scale);
    end

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      apply_setting(ph);
      if (ph == 3) begin
        tx_idle_pct = 57;
        rx_idle_pct = 6;
      end else if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (ph == 0) begin
        tx_idle_pct = 6;
        rx_idle_pct = 57;
      end
      for (int k = 0; k < 175; k++) random_word();
    end

    drain();
    if (swing_q.size() != 0) begin
      $error("plate_swing: %0d expected words never arrived", swing_q.size());
      errors++;
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
